[src/bpi_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpi_pkg
// Shared widths, types and helpers for the biquadratic pixel interpolator.
// ---------------------------------------------------------------------------
package bpi_pkg;

	// fraction bits of the sample offsets and of the column intermediates
	localparam int FRAC_BITS = 8;

	localparam int PIX_W     = 8;                  // pixel width
	localparam int FRAC_IN_W = 8;                  // width of the frac fields
	localparam int WIN_N     = 9;                  // pixels in a 3x3 window
	localparam int NUM_COLS  = 3;                  // columns (and rows) in the window

	// offset bits actually taken from a frac field
	localparam int FRAC_USE  = (FRAC_BITS < FRAC_IN_W) ? FRAC_BITS : FRAC_IN_W;

	// position 1+frac and its square, unsigned
	localparam int POS_W     = FRAC_BITS + 1;
	localparam int POSSQ_W   = 2 * POS_W;

	// column pass: a = p0-2p1+p2, c = -3p0+4p1-p2, scaled sum
	localparam int CA_W      = PIX_W + 2;
	localparam int CC_W      = PIX_W + 4;
	localparam int COL_SUM_W = POSSQ_W + CA_W + 2;

	// column result, F fraction bits, signed with headroom for overshoot
	localparam int COL_W     = PIX_W + FRAC_BITS + 3;

	// row pass over the column results
	localparam int RA_W      = COL_W + 2;
	localparam int RC_W      = COL_W + 4;
	localparam int ROW_SUM_W = POSSQ_W + RA_W + 2;

	// fraction bits of the row sum and width of its integer part
	localparam int ROW_FRAC  = 3 * FRAC_BITS + 1;
	localparam int ACC_INT_W = ROW_SUM_W - ROW_FRAC;

	typedef logic [PIX_W-1:0]             pix_t;
	typedef pix_t [WIN_N-1:0]             win_t;
	typedef logic [FRAC_IN_W-1:0]         frac_t;
	typedef logic [POS_W-1:0]             pos_t;
	typedef logic [POSSQ_W-1:0]           possq_t;
	typedef logic signed [COL_W-1:0]      col_t;
	typedef logic signed [COL_SUM_W-1:0]  col_sum_t;
	typedef logic signed [ROW_SUM_W-1:0]  row_sum_t;

	localparam pix_t PIX_MAX = '1;

	// 1+frac as an unsigned fixed-point position; extra frac bits are dropped
	function automatic pos_t frac_pos(input frac_t raw);
		pos_t t;
		t = '0;
		for (int i = 0; i < FRAC_USE; i++) begin
			t[i] = raw[i];
		end
		t[FRAC_BITS] = 1'b1;
		return t;
	endfunction

endpackage

[src/bpi_col_pass.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpi_col_pass
// Vertical pass: three-stage pipeline evaluating the quadratic through each
// column at 1+frac_y, floored to FRAC_BITS fraction bits.
// ---------------------------------------------------------------------------
module bpi_col_pass (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  bpi_pkg::win_t   win,
	input  bpi_pkg::frac_t  frac_x,
	input  bpi_pkg::frac_t  frac_y,
	output logic            out_valid,
	input  logic            out_stall,
	output bpi_pkg::col_t   col [bpi_pkg::NUM_COLS],
	output bpi_pkg::pos_t   tx
);
	import bpi_pkg::*;

	// stage valids and load enables
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;

	// stage 1: node differences and squared position
	logic signed [CA_W-1:0] a_n  [NUM_COLS];
	logic signed [CC_W-1:0] c_n  [NUM_COLS];
	logic signed [CA_W-1:0] a_s1 [NUM_COLS];
	logic signed [CC_W-1:0] c_s1 [NUM_COLS];
	pix_t                   p0_s1 [NUM_COLS];
	pos_t                   ty_n, ty_s1, tx_s1;
	possq_t                 tysq_n, tysq_s1;

	// stage 2: products
	col_sum_t               pa_s2 [NUM_COLS];
	col_sum_t               pc_s2 [NUM_COLS];
	pix_t                   p0_s2 [NUM_COLS];
	pos_t                   tx_s2;

	// stage 3: scaled sum, floored
	col_t                   col_n [NUM_COLS];
	col_t                   col_s3 [NUM_COLS];
	pos_t                   tx_s3;

	// a stage loads when empty or when the next one moves
	assign en3      = !v_s3 || !out_stall;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_stall = !en1;

	// per-column coefficients; node rows are up, mid, down
	always_comb begin
		logic signed [PIX_W:0] pe0, pe1, pe2;
		for (int i = 0; i < NUM_COLS; i++) begin
			pe0    = {1'b0, win[i]};
			pe1    = {1'b0, win[NUM_COLS + i]};
			pe2    = {1'b0, win[2*NUM_COLS + i]};
			a_n[i] = CA_W'(pe0) - (CA_W'(pe1) <<< 1) + CA_W'(pe2);
			c_n[i] = (CC_W'(pe1) <<< 2) - (CC_W'(pe0) <<< 1) - CC_W'(pe0) - CC_W'(pe2);
		end
		ty_n   = frac_pos(frac_y);
		tysq_n = POSSQ_W'(ty_n) * POSSQ_W'(ty_n);
	end

	// T^2*a + T*2^F*c + p0*2^(2F+1), then floor by 2^(F+1)
	always_comb begin
		col_sum_t s;
		col_sum_t p0t;
		for (int i = 0; i < NUM_COLS; i++) begin
			p0t      = col_sum_t'({1'b0, p0_s2[i]});
			s        = pa_s2[i] + (pc_s2[i] <<< FRAC_BITS) + (p0t <<< (2*FRAC_BITS + 1));
			col_n[i] = COL_W'(s >>> (FRAC_BITS + 1));
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (en1) begin
			for (int i = 0; i < NUM_COLS; i++) begin
				a_s1[i]  <= a_n[i];
				c_s1[i]  <= c_n[i];
				p0_s1[i] <= win[i];
			end
			ty_s1   <= ty_n;
			tysq_s1 <= tysq_n;
			tx_s1   <= frac_pos(frac_x);
		end
		if (en2) begin
			for (int i = 0; i < NUM_COLS; i++) begin
				pa_s2[i] <= $signed({1'b0, tysq_s1}) * a_s1[i];
				pc_s2[i] <= $signed({1'b0, ty_s1}) * c_s1[i];
				p0_s2[i] <= p0_s1[i];
			end
			tx_s2 <= tx_s1;
		end
		if (en3) begin
			for (int i = 0; i < NUM_COLS; i++) begin
				col_s3[i] <= col_n[i];
			end
			tx_s3 <= tx_s2;
		end
	end

	assign out_valid = v_s3;
	assign col       = col_s3;
	assign tx        = tx_s3;

endmodule

[src/bpi_row_pass.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpi_row_pass
// Horizontal pass: three-stage pipeline evaluating the quadratic through the
// column results at 1+frac_x, then truncating and clamping to a pixel.
// ---------------------------------------------------------------------------
module bpi_row_pass (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  bpi_pkg::col_t  col [bpi_pkg::NUM_COLS],
	input  bpi_pkg::pos_t  tx,
	output logic           out_valid,
	input  logic           out_stall,
	output bpi_pkg::pix_t  sample_value
);
	import bpi_pkg::*;

	logic v_s4, v_s5, v_s6;
	logic en4, en5, en6;

	// stage 4: differences of column results, squared position
	logic signed [RA_W-1:0] ra_n, ra_s4;
	logic signed [RC_W-1:0] rc_n, rc_s4;
	col_t                   c0_s4, c0_s5;
	pos_t                   tx_s4;
	possq_t                 txsq_n, txsq_s4;

	// stage 5: products
	row_sum_t               pa_s5, pc_s5;

	// stage 6: clamped pixel
	pix_t                   pix_n, pix_s6;

	assign en6      = !v_s6 || !out_stall;
	assign en5      = !v_s5 || en6;
	assign en4      = !v_s4 || en5;
	assign in_stall = !en4;

	// coefficients over the three column results
	always_comb begin
		ra_n   = RA_W'(col[0]) - (RA_W'(col[1]) <<< 1) + RA_W'(col[2]);
		rc_n   = (RC_W'(col[1]) <<< 2) - (RC_W'(col[0]) <<< 1) - RC_W'(col[0])
		         - RC_W'(col[2]);
		txsq_n = POSSQ_W'(tx) * POSSQ_W'(tx);
	end

	// exact sum, truncate toward zero, clamp to 0..PIX_MAX
	always_comb begin
		row_sum_t               acc;
		row_sum_t               c0t;
		logic [ACC_INT_W-1:0]   ip;
		c0t = row_sum_t'(c0_s5);
		acc = pa_s5 + (pc_s5 <<< FRAC_BITS) + (c0t <<< (2*FRAC_BITS + 1));
		ip  = acc[ROW_SUM_W-1:ROW_FRAC];
		if (acc[ROW_SUM_W-1] || (acc == '0)) begin
			pix_n = '0;
		end else if (ip > ACC_INT_W'(PIX_MAX)) begin
			pix_n = PIX_MAX;
		end else begin
			pix_n = ip[PIX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (en4) v_s4 <= in_valid;
			if (en5) v_s5 <= v_s4;
			if (en6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) begin
			ra_s4   <= ra_n;
			rc_s4   <= rc_n;
			c0_s4   <= col[0];
			tx_s4   <= tx;
			txsq_s4 <= txsq_n;
		end
		if (en5) begin
			pa_s5 <= $signed({1'b0, txsq_s4}) * ra_s4;
			pc_s5 <= $signed({1'b0, tx_s4}) * rc_s4;
			c0_s5 <= c0_s4;
		end
		if (en6) begin
			pix_s6 <= pix_n;
		end
	end

	assign out_valid    = v_s6;
	assign sample_value = pix_s6;

endmodule

[src/biquadratic_pixel_interpolator_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// biquadratic_pixel_interpolator_unit
// 3x3 biquadratic (quadratic Lagrange) pixel interpolator, fixed point.
//
//   channel  handshake            payload
//   in       in_valid / in_stall  pix_up_left .. pix_down_right, frac_x, frac_y
//   out      out_valid/ out_stall sample_value
//
// One word per clock sustained while out_stall is low; three column-pass
// stages, three row-pass stages, the last being the output register.
// Each stage loads when it is empty or the next stage moves, so an output
// stall only backs up as far as the pipeline is full; bubbles close up.
// Reset clears the stage valid bits only.
// ---------------------------------------------------------------------------
module biquadratic_pixel_interpolator_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  bpi_pkg::pix_t   pix_up_left,
	input  bpi_pkg::pix_t   pix_up_mid,
	input  bpi_pkg::pix_t   pix_up_right,
	input  bpi_pkg::pix_t   pix_mid_left,
	input  bpi_pkg::pix_t   pix_center,
	input  bpi_pkg::pix_t   pix_mid_right,
	input  bpi_pkg::pix_t   pix_down_left,
	input  bpi_pkg::pix_t   pix_down_mid,
	input  bpi_pkg::pix_t   pix_down_right,
	input  bpi_pkg::frac_t  frac_x,
	input  bpi_pkg::frac_t  frac_y,
	output logic            out_valid,
	input  logic            out_stall,
	output bpi_pkg::pix_t   sample_value
);
	import bpi_pkg::*;

	// window in row-major order, up-left at index zero
	win_t  win;
	col_t  col_w [NUM_COLS];
	pos_t  tx_w;
	logic  mid_valid;
	logic  mid_stall;

	assign win = {pix_down_right, pix_down_mid, pix_down_left,
	              pix_mid_right,  pix_center,   pix_mid_left,
	              pix_up_right,   pix_up_mid,   pix_up_left};

	bpi_col_pass u_col (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.win       (win),
		.frac_x    (frac_x),
		.frac_y    (frac_y),
		.out_valid (mid_valid),
		.out_stall (mid_stall),
		.col       (col_w),
		.tx        (tx_w)
	);

	bpi_row_pass u_row (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (mid_valid),
		.in_stall     (mid_stall),
		.col          (col_w),
		.tx           (tx_w),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sample_value (sample_value)
	);

endmodule

[tb/biquadratic_pixel_interpolator_unit_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// biquadratic_pixel_interpolator_unit_test
// Self-checking bench for the 3x3 biquadratic pixel interpolator.
//
// Each accepted window is run through a fixed-point model of the two
// quadratic passes: columns first, floored to FRAC_BITS fraction bits, then
// across the three column results. The final value is truncated toward zero
// and clamped to 0..255. Expected samples are queued in order and compared
// with every word that leaves the block. The run starts with hand-picked
// windows: flat fields, full-scale offsets, one bit of offset at a time, and
// shapes that push the curve below zero or above full scale in either
// direction. Random windows follow, some uniform noise and some image-like
// (ramps, hard edges, near-black, near-white), with random input gaps and
// output stalls in some phases and none in others.
// ---------------------------------------------------------------------------
module biquadratic_pixel_interpolator_unit_test;
	import bpi_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 12;

	typedef pix_t pix_window_t [WIN_N];

	typedef enum int {
		WIN_UNIFORM,
		WIN_BINARY,
		WIN_DARK,
		WIN_BRIGHT,
		WIN_RAMP
	} window_kind_t;

	typedef struct {
		pix_t        value;
		int unsigned word_idx;
	} pending_sample_t;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_stall;
	pix_t  pix_up_left = '0;
	pix_t  pix_up_mid = '0;
	pix_t  pix_up_right = '0;
	pix_t  pix_mid_left = '0;
	pix_t  pix_center = '0;
	pix_t  pix_mid_right = '0;
	pix_t  pix_down_left = '0;
	pix_t  pix_down_mid = '0;
	pix_t  pix_down_right = '0;
	frac_t frac_x = '0;
	frac_t frac_y = '0;
	logic  out_valid;
	logic  out_stall = 1'b0;
	pix_t  sample_value;

	pending_sample_t pending_samples[$];

	int unsigned words_sent = 0;
	int unsigned samples_checked = 0;
	int unsigned zero_clamps = 0;
	int unsigned full_clamps = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	// idling knobs, percent chance per word / per cycle
	int unsigned in_gap_pct = 0;
	int unsigned out_stall_pct = 0;
	int unsigned stall_left = 0;

	biquadratic_pixel_interpolator_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.pix_up_left    (pix_up_left),
		.pix_up_mid     (pix_up_mid),
		.pix_up_right   (pix_up_right),
		.pix_mid_left   (pix_mid_left),
		.pix_center     (pix_center),
		.pix_mid_right  (pix_mid_right),
		.pix_down_left  (pix_down_left),
		.pix_down_mid   (pix_down_mid),
		.pix_down_right (pix_down_right),
		.frac_x         (frac_x),
		.frac_y         (frac_y),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.sample_value   (sample_value)
	);

	always #1 clk = ~clk;

	// ------------------------------------------------------------------
	// Fixed-point prediction
	// ------------------------------------------------------------------

	// quadratic through nodes at 0,1,2, evaluated at pos; scaled by 2^(2F+1)
	function automatic longint lagrange_scaled(longint n0, longint n1, longint n2,
			longint pos);
		longint a, c, unit_pos;
		a        = n0 - 2 * n1 + n2;
		c        = -3 * n0 + 4 * n1 - n2;
		unit_pos = longint'(1) << FRAC_BITS;
		return pos * pos * a + pos * unit_pos * c + n0 * 2 * unit_pos * unit_pos;
	endfunction

	// position 1+frac; offset bits above FRAC_BITS are dropped
	function automatic longint offset_pos(frac_t raw);
		longint f;
		f = longint'(raw) & ((longint'(1) << FRAC_BITS) - 1);
		return f + (longint'(1) << FRAC_BITS);
	endfunction

	function automatic pix_t predict_sample(pix_window_t w, frac_t fx, frac_t fy);
		longint col_val [NUM_COLS];
		longint tx, ty, acc, whole;
		tx = offset_pos(fx);
		ty = offset_pos(fy);
		// column pass, floored to F fraction bits
		for (int i = 0; i < NUM_COLS; i++) begin
			col_val[i] = lagrange_scaled(w[i], w[3 + i], w[6 + i], ty) >>> (FRAC_BITS + 1);
		end
		// row pass is exact, 3F+1 fraction bits
		acc = lagrange_scaled(col_val[0], col_val[1], col_val[2], tx);
		if (acc <= 0) begin
			return '0;
		end
		whole = acc >>> (3 * FRAC_BITS + 1);
		if (whole > longint'(PIX_MAX)) begin
			return PIX_MAX;
		end
		return pix_t'(whole);
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	// mostly short, now and then long
	function automatic int unsigned pick_idle_len();
		if ($urandom_range(9) == 0) begin
			return $urandom_range(30, 8);
		end
		return $urandom_range(3, 1);
	endfunction

	function automatic frac_t random_offset();
		int unsigned r;
		r = $urandom_range(9);
		if (r == 0) begin
			return '0;
		end
		if (r == 1) begin
			return '1;
		end
		return frac_t'($urandom);
	endfunction

	function automatic pix_window_t random_window(window_kind_t kind);
		pix_window_t w;
		int base, dx, dy, v;
		base = $urandom_range(255);
		dx   = $urandom_range(120) - 60;
		dy   = $urandom_range(120) - 60;
		for (int i = 0; i < WIN_N; i++) begin
			case (kind)
				WIN_UNIFORM: begin
					w[i] = pix_t'($urandom);
				end
				WIN_BINARY: begin
					w[i] = ($urandom_range(1) == 1) ? PIX_MAX : pix_t'(0);
				end
				WIN_DARK: begin
					w[i] = pix_t'($urandom_range(12));
				end
				WIN_BRIGHT: begin
					w[i] = PIX_MAX - pix_t'($urandom_range(12));
				end
				default: begin
					v = base + dx * (i % 3) + dy * (i / 3) + $urandom_range(6) - 3;
					if (v < 0) v = 0;
					if (v > 255) v = 255;
					w[i] = pix_t'(v);
				end
			endcase
		end
		return w;
	endfunction

	function automatic pix_window_t flat_window(pix_t v);
		pix_window_t w;
		for (int i = 0; i < WIN_N; i++) begin
			w[i] = v;
		end
		return w;
	endfunction

	// present one window; returns at the rising edge that takes it, or later after a random input gap
	task automatic send_word(input pix_window_t w, input frac_t fx, input frac_t fy);
		pending_sample_t entry;
		pix_up_left    <= w[0];
		pix_up_mid     <= w[1];
		pix_up_right   <= w[2];
		pix_mid_left   <= w[3];
		pix_center     <= w[4];
		pix_mid_right  <= w[5];
		pix_down_left  <= w[6];
		pix_down_mid   <= w[7];
		pix_down_right <= w[8];
		frac_x         <= fx;
		frac_y         <= fy;
		in_valid       <= 1'b1;
		do @(posedge clk); while (in_stall);
		entry.value    = predict_sample(w, fx, fy);
		entry.word_idx = words_sent;
		pending_samples.push_back(entry);
		words_sent++;
		if (entry.value == '0) zero_clamps++;
		if (entry.value == PIX_MAX) full_clamps++;
		if (in_gap_pct > 0 && $urandom_range(99) < in_gap_pct) begin
			in_valid <= 1'b0;
			repeat (pick_idle_len()) @(posedge clk);
		end
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// flat fields, offset extremes, one offset bit at a time
	task automatic test_flat_and_offsets();
		pix_window_t w;
		in_gap_pct    = 30;
		out_stall_pct = 20;
		send_word(flat_window('0), '0, '0);
		send_word(flat_window(PIX_MAX), '1, '1);
		send_word(flat_window(PIX_MAX), '0, '0);
		send_word(flat_window('0), '1, 8'h80);
		send_word(flat_window(8'd1), 8'h01, 8'h01);
		w = '{8'd0, 8'd32, 8'd64, 8'd48, 8'd80, 8'd112, 8'd96, 8'd128, 8'd160};
		send_word(w, '1, '1);
		for (int k = 0; k < FRAC_IN_W; k++) begin
			send_word(random_window(WIN_UNIFORM), frac_t'(1) << k, frac_t'(8'h80) >> k);
		end
	endtask

	// curves that undershoot zero or overshoot full scale, per axis
	task automatic test_overshoot();
		pix_window_t w;
		in_gap_pct    = 20;
		out_stall_pct = 30;
		// column pass goes negative
		w = '{8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
		send_word(w, '0, 8'h80);
		// column pass goes above full scale
		w = '{8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
		send_word(w, '0, 8'h80);
		// row pass goes negative
		w = '{8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0};
		send_word(w, 8'h80, '0);
		// row pass goes above full scale
		w = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255, 8'd255};
		send_word(w, 8'h80, '0);
		// lone bright center pixel
		w = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0};
		send_word(w, 8'h80, 8'h80);
		// checkerboard
		w = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd255};
		send_word(w, 8'h55, 8'hAA);
	endtask

	// back-to-back words, no input gaps and no new output stalls
	task automatic test_steady_stream(int unsigned n);
		in_gap_pct    = 0;
		out_stall_pct = 0;
		repeat (n) begin
			send_word(random_window(WIN_UNIFORM), random_offset(), random_offset());
		end
	endtask

	// uniform noise with gaps and stalls on both sides
	task automatic test_random_windows(int unsigned n);
		in_gap_pct    = 25;
		out_stall_pct = 25;
		repeat (n) begin
			send_word(random_window(WIN_UNIFORM), random_offset(), random_offset());
		end
	endtask

	// uniform noise, ramps, hard edges and near-saturated fields under heavy backpressure
	task automatic test_image_like(int unsigned n);
		in_gap_pct    = 10;
		out_stall_pct = 50;
		repeat (n) begin
			send_word(random_window(window_kind_t'($urandom_range(WIN_RAMP))),
				random_offset(), random_offset());
		end
	endtask

	// ------------------------------------------------------------------
	// Output stall generator
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (out_stall_pct > 0 && $urandom_range(99) < out_stall_pct) begin
			out_stall  <= 1'b1;
			stall_left <= pick_idle_len() - 1;
		end else begin
			out_stall  <= 1'b0;
		end
	end

	// ------------------------------------------------------------------
	// Result checker
	// ------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		$display("ERROR @%0d cycles: %s", cycles, msg);
		mismatches++;
	endtask

	always @(posedge clk) begin : check_samples
		pending_sample_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_samples.size() == 0) begin
				report_mismatch($sformatf("sample_value %0d with no word pending",
					sample_value));
			end else begin
				want = pending_samples.pop_front();
				samples_checked++;
				if (sample_value !== want.value) begin
					report_mismatch($sformatf("word %0d: sample_value %0d, want %0d",
						want.word_idx, sample_value, want.value));
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("ERROR: timeout with %0d samples pending", pending_samples.size());
			$display("** biquadratic_pixel_interpolator_unit: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_flat_and_offsets();
		test_overshoot();
		test_steady_stream(150);
		test_random_windows(700);
		test_image_like(250);
		in_valid <= 1'b0;
		in_gap_pct    = 0;
		out_stall_pct = 0;

		while (pending_samples.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Ran %0d windows, %0d samples checked (%0d at zero, %0d at full scale),",
			words_sent, samples_checked, zero_clamps, full_clamps);
		$display("under input gaps and output stalls; %0d mismatches.", mismatches);
		if (mismatches == 0) begin
			$display("** biquadratic_pixel_interpolator_unit: PASSED **");
		end else begin
			$display("** biquadratic_pixel_interpolator_unit: FAILED **");
		end
		$finish;
	end

endmodule
